/* hw/rtl/plbm_pkg.sv */
// plbm_pkg: shared types and constants for the parallel panel bus master
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package plbm_pkg;

  localparam int DATA_W  = 16;
  localparam int FUNC_W  = 2;
  localparam int HOLD_W  = 10;
  localparam int PHASE_W = 3;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_CMD_WR    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DATA_WR   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DATA_RD   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_PANEL_RST = 2'd3;

  // index of the final phase of each request
  localparam logic [PHASE_W-1:0] PH_LAST_WR  = 3'd6;
  localparam logic [PHASE_W-1:0] PH_LAST_RD  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_LAST_RST = 3'd2;

  // phases with a chip select edge, the start of the data drive, a strobe or a reset pulse
  localparam logic [PHASE_W-1:0] PH_CS_FIRST = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WR_CS_END = 3'd4;
  localparam logic [PHASE_W-1:0] PH_WR_DRIVE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WR_STROBE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RD_STROBE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RST_LOW  = 3'd1;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 10'd500;
  localparam logic [HOLD_W-1:0] HOLD_MIN   = 10'd1;
  localparam logic [HOLD_W-1:0] HOLD_MAX   = 10'd1000;

  localparam logic [DATA_W-1:0] CMD_MASK = 16'h00ff;

  localparam int QUEUE_DEPTH = 2;

  // one classified request waiting for the sequencer
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] sample;
    logic [HOLD_W-1:0] hold;
  } plbm_cmd_t;

  // front to queue
  typedef struct packed {
    logic      push;
    plbm_cmd_t cmd;
  } plbm_push_t;

  // queue to back
  typedef struct packed {
    logic      valid;
    plbm_cmd_t cmd;
  } plbm_head_t;

endpackage

`default_nettype wire

/* hw/rtl/plbm_in_if.sv */
// plbm_in_if: request channel of the panel bus master
// depends on plbm_pkg for field widths
`default_nettype none

interface plbm_in_if;
  logic                          valid;
  logic                          ready;
  logic [plbm_pkg::FUNC_W-1:0]   func;
  logic [plbm_pkg::DATA_W-1:0]   value;
  logic [plbm_pkg::DATA_W-1:0]   bus_in;

  modport source (output valid, output func, output value, output bus_in, input ready);
  modport sink (input valid, input func, input value, input bus_in, output ready);
endinterface

`default_nettype wire

/* hw/rtl/plbm_out_if.sv */
// plbm_out_if: pin phase channel of the panel bus master
// depends on plbm_pkg for field widths
`default_nettype none

interface plbm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          cs_n;
  logic                          dc;
  logic                          wr_n;
  logic                          rd_n;
  logic                          reset_n;
  logic [plbm_pkg::DATA_W-1:0]   data_out;
  logic                          data_drive;
  logic [plbm_pkg::DATA_W-1:0]   read_data;
  logic [plbm_pkg::HOLD_W-1:0]   hold_ms;
  logic                          last;

  modport source (output valid, output cs_n, output dc, output wr_n, output rd_n,
                  output reset_n, output data_out, output data_drive, output read_data,
                  output hold_ms, output last, input ready);
  modport sink (input valid, input cs_n, input dc, input wr_n, input rd_n,
                input reset_n, input data_out, input data_drive, input read_data,
                input hold_ms, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/plbm_front.sv */
// plbm_front: accepts requests, masks words to the bus, clamps the reset hold time
// depends on plbm_pkg and plbm_in_if; feeds plbm_queue
`default_nettype none

module plbm_front #(
  parameter int BUS_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  plbm_in_if.sink                            in_ch,
  input  wire logic                          cfg_we,
  input  wire logic [plbm_pkg::HOLD_W-1:0]   cfg_data,
  input  wire logic                          q_full,
  output plbm_pkg::plbm_push_t               q_push
);

  localparam int MASK_BITS = (BUS_WIDTH >= plbm_pkg::DATA_W) ? plbm_pkg::DATA_W : BUS_WIDTH;
  localparam logic [plbm_pkg::DATA_W:0] MASK_WIDE = (17'd1 << MASK_BITS) - 17'd1;
  localparam logic [plbm_pkg::DATA_W-1:0] BUS_MASK = MASK_WIDE[plbm_pkg::DATA_W-1:0];

  logic [plbm_pkg::HOLD_W-1:0] hold_cfg_r;
  logic [plbm_pkg::HOLD_W-1:0] hold_clamped;
  logic [plbm_pkg::DATA_W-1:0] word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_cfg_r <= plbm_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      hold_cfg_r <= cfg_data;
    end
  end

  always_comb begin
    if (hold_cfg_r == '0) begin
      hold_clamped = plbm_pkg::HOLD_MIN;
    end else if (hold_cfg_r > plbm_pkg::HOLD_MAX) begin
      hold_clamped = plbm_pkg::HOLD_MAX;
    end else begin
      hold_clamped = hold_cfg_r;
    end
  end

  // command writes carry only the low byte
  always_comb begin
    if (in_ch.func == plbm_pkg::FUNC_CMD_WR) begin
      word = in_ch.value & plbm_pkg::CMD_MASK & BUS_MASK;
    end else begin
      word = in_ch.value & BUS_MASK;
    end
  end

  assign in_ch.ready         = !q_full;
  assign q_push.push         = in_ch.valid && !q_full;
  assign q_push.cmd.func     = in_ch.func;
  assign q_push.cmd.word     = word;
  assign q_push.cmd.sample   = in_ch.bus_in & BUS_MASK;
  assign q_push.cmd.hold     = hold_clamped;

endmodule

`default_nettype wire

/* hw/rtl/plbm_queue.sv */
// plbm_queue: short request queue between the front and the phase sequencer
// depends on plbm_pkg
`default_nettype none

module plbm_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire plbm_pkg::plbm_push_t q_push,
  input  wire logic                 pop,
  output logic                      full,
  output plbm_pkg::plbm_head_t      head
);

  localparam int DEPTH = plbm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  plbm_pkg::plbm_cmd_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head.valid = (count_r != '0);
  assign head.cmd   = entry_r[rd_ptr_r];
  assign do_push    = q_push.push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= q_push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

/* hw/rtl/plbm_back.sv */
// plbm_back: phase sequencer, one pin phase per unstalled cycle into an output register
// depends on plbm_pkg and plbm_out_if; fed by plbm_queue
`default_nettype none

module plbm_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire plbm_pkg::plbm_head_t head,
  output logic                      pop,
  plbm_out_if.source                out_ch
);

  logic                            out_valid_r;
  logic                            busy_r;
  logic [plbm_pkg::PHASE_W-1:0]    phase_r;
  plbm_pkg::plbm_cmd_t             cur_r;
  logic [plbm_pkg::DATA_W-1:0]     latch_r;

  logic                            cs_n_r, dc_r, wr_n_r, rd_n_r, reset_n_r, drive_r, last_r;
  logic [plbm_pkg::DATA_W-1:0]     data_out_r, read_data_r;
  logic [plbm_pkg::HOLD_W-1:0]     hold_r;

  logic                            adv;
  logic                            have;
  plbm_pkg::plbm_cmd_t             sel;
  logic [plbm_pkg::PHASE_W-1:0]    ph;

  logic                            p_cs_n, p_dc, p_wr_n, p_rd_n, p_reset_n, p_drive, p_last;
  logic [plbm_pkg::DATA_W-1:0]     p_dout, p_rdata;
  logic [plbm_pkg::HOLD_W-1:0]     p_hold;

  // a new request is popped once the previous one's last phase is in the output register
  assign adv  = !out_valid_r || out_ch.ready;
  assign have = busy_r || head.valid;
  assign sel  = busy_r ? cur_r : head.cmd;
  assign ph   = busy_r ? phase_r : '0;
  assign pop  = adv && !busy_r && head.valid;

  always_comb begin
    p_cs_n    = 1'b1;
    p_dc      = 1'b1;
    p_wr_n    = 1'b1;
    p_rd_n    = 1'b1;
    p_reset_n = 1'b1;
    p_drive   = 1'b1;
    p_rdata   = '0;
    p_hold    = '0;
    p_last    = 1'b0;
    p_dout    = latch_r;
    case (sel.func)
      plbm_pkg::FUNC_CMD_WR, plbm_pkg::FUNC_DATA_WR: begin
        p_cs_n = !(ph inside {[plbm_pkg::PH_CS_FIRST:plbm_pkg::PH_WR_CS_END]});
        p_dc   = (ph == plbm_pkg::PH_LAST_WR) ? 1'b1 : (sel.func == plbm_pkg::FUNC_DATA_WR);
        p_wr_n = (ph != plbm_pkg::PH_WR_STROBE);
        p_last = (ph == plbm_pkg::PH_LAST_WR);
        if (ph >= plbm_pkg::PH_WR_DRIVE) begin
          p_dout = sel.word;
        end
      end
      plbm_pkg::FUNC_DATA_RD: begin
        p_drive = 1'b0;
        p_cs_n  = (ph == '0) || (ph == plbm_pkg::PH_LAST_RD);
        p_rd_n  = (ph != plbm_pkg::PH_RD_STROBE);
        p_rdata = (ph == plbm_pkg::PH_RD_STROBE) ? sel.sample : '0;
        p_last  = (ph == plbm_pkg::PH_LAST_RD);
      end
      default: begin
        p_reset_n = (ph != plbm_pkg::PH_RST_LOW);
        p_hold    = sel.hold;
        p_last    = (ph == plbm_pkg::PH_LAST_RST);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      phase_r     <= '0;
      latch_r     <= '0;
    end else if (adv) begin
      out_valid_r <= have;
      if (have) begin
        latch_r <= p_dout;
        if (p_last) begin
          busy_r  <= 1'b0;
          phase_r <= '0;
        end else begin
          busy_r  <= 1'b1;
          phase_r <= ph + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && have) begin
      cur_r       <= sel;
      cs_n_r      <= p_cs_n;
      dc_r        <= p_dc;
      wr_n_r      <= p_wr_n;
      rd_n_r      <= p_rd_n;
      reset_n_r   <= p_reset_n;
      drive_r     <= p_drive;
      last_r      <= p_last;
      data_out_r  <= p_dout;
      read_data_r <= p_rdata;
      hold_r      <= p_hold;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cs_n       = cs_n_r;
  assign out_ch.dc         = dc_r;
  assign out_ch.wr_n       = wr_n_r;
  assign out_ch.rd_n       = rd_n_r;
  assign out_ch.reset_n    = reset_n_r;
  assign out_ch.data_out   = data_out_r;
  assign out_ch.data_drive = drive_r;
  assign out_ch.read_data  = read_data_r;
  assign out_ch.hold_ms    = hold_r;
  assign out_ch.last       = last_r;

  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (phase_r != '0))
    else $error("sequencer busy at phase zero");

  a_strobes_apart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (wr_n_r || rd_n_r))
    else $error("write and read strobes low together");

  a_read_released: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !rd_n_r) |-> (!drive_r && !cs_n_r))
    else $error("read strobe without released bus and chip select");

  a_hold_reset_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (hold_r != '0)) |-> (cs_n_r && wr_n_r && rd_n_r))
    else $error("hold time outside a reset phase");

endmodule

`default_nettype wire

/* hw/rtl/parallel_lcd_bus_master.sv */
// parallel_lcd_bus_master: top level of the 8080-style 16-bit panel bus master
// depends on plbm_pkg, plbm_in_if, plbm_out_if, plbm_front, plbm_queue, plbm_back
//
//   port      dir  handshake      carries
//   in_ch     in   valid/ready    func, value, bus_in
//   out_ch    out  valid/ready    one pin phase: strobes, data, hold_ms, last
//   cfg_*     in   cfg_we only    reset_hold_ms (10 bits)
//
// the sequencer emits one phase per cycle while out_ch is not stalled; a write has the most phases, a reset the fewest
// consecutive requests run without a gap; the phase count of the sequencer sets the rate
// synchronous active-low reset: data pins word 0, hold time 500 ms, queue empty
// out_ch.ready low freezes the sequencer; the two-entry queue keeps taking requests until full
`default_nettype none

module parallel_lcd_bus_master #(
  parameter int BUS_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  plbm_in_if.sink                            in_ch,
  plbm_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [plbm_pkg::HOLD_W-1:0]   cfg_data
);

  plbm_pkg::plbm_push_t q_push;
  plbm_pkg::plbm_head_t q_head;
  logic                 q_full;
  logic                 q_pop;

  plbm_front #(
    .BUS_WIDTH (BUS_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  plbm_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .full   (q_full),
    .head   (q_head)
  );

  plbm_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

/* bench/tb.sv */
// tb: self-checking bench for parallel_lcd_bus_master, predicts every pin phase of each request
// depends on plbm_pkg, plbm_in_if, plbm_out_if and the rtl of the block
// random handshake gaps on both channels, hold time register swept through its extremes

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W = plbm_pkg::DATA_W;
  localparam int HOLD_W = plbm_pkg::HOLD_W;
  localparam int FUNC_W = plbm_pkg::FUNC_W;

  localparam int BUS_W = 16;
  localparam logic [DATA_W-1:0] BUS_MASK =
    (BUS_W >= DATA_W) ? '1 : DATA_W'((1 << BUS_W) - 1);
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic              cs_n;
    logic              dc;
    logic              wr_n;
    logic              rd_n;
    logic              reset_n;
    logic [DATA_W-1:0] data_out;
    logic              data_drive;
    logic [DATA_W-1:0] read_data;
    logic [HOLD_W-1:0] hold_ms;
    logic              last;
  } pin_phase_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [HOLD_W-1:0] cfg_data;

  plbm_in_if  in_ch ();
  plbm_out_if out_ch ();

  parallel_lcd_bus_master #(
    .BUS_WIDTH(BUS_W)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // own copy of the block state
  logic [DATA_W-1:0] pins_word;
  logic [HOLD_W-1:0] hold_setting;
  pin_phase_t        phases_due[$];

  int mismatches = 0;
  int phases_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at phase %0d: %s", phases_seen, msg);
    mismatches++;
  endtask

  task automatic push_phase(input logic cs_n, input logic dc, input logic wr_n, input logic rd_n,
                            input logic rst, input logic drive, input logic [DATA_W-1:0] rdata,
                            input logic [HOLD_W-1:0] hold, input logic last);
    pin_phase_t p;
    p.cs_n       = cs_n;
    p.dc         = dc;
    p.wr_n       = wr_n;
    p.rd_n       = rd_n;
    p.reset_n    = rst;
    p.data_out   = pins_word;
    p.data_drive = drive;
    p.read_data  = rdata;
    p.hold_ms    = hold;
    p.last       = last;
    phases_due.push_back(p);
  endtask

  task automatic predict_pin_phases(input logic [FUNC_W-1:0] func,
                                    input logic [DATA_W-1:0] value,
                                    input logic [DATA_W-1:0] bus_in);
    logic              rs;
    logic [DATA_W-1:0] sample;
    logic [HOLD_W-1:0] hold;
    sample = bus_in & BUS_MASK;
    case (func)
      plbm_pkg::FUNC_CMD_WR, plbm_pkg::FUNC_DATA_WR: begin
        rs = (func == plbm_pkg::FUNC_DATA_WR);
        push_phase(1'b1, rs, 1'b1, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0);
        push_phase(1'b0, rs, 1'b1, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0);
        // the new word shows up from the drive phase on
        pins_word = ((func == plbm_pkg::FUNC_CMD_WR) ? (value & plbm_pkg::CMD_MASK) : value)
                    & BUS_MASK;
        push_phase(1'b0, rs, 1'b1, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0);
        push_phase(1'b0, rs, 1'b0, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0);
        push_phase(1'b0, rs, 1'b1, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0);
        push_phase(1'b1, rs, 1'b1, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0);
        push_phase(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, '0, '0, 1'b1);
      end
      plbm_pkg::FUNC_DATA_RD: begin
        push_phase(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0);
        push_phase(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0);
        push_phase(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, sample, '0, 1'b0);
        push_phase(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0);
        push_phase(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0, '0, 1'b1);
      end
      default: begin
        hold = hold_setting;
        if (hold < plbm_pkg::HOLD_MIN) hold = plbm_pkg::HOLD_MIN;
        if (hold > plbm_pkg::HOLD_MAX) hold = plbm_pkg::HOLD_MAX;
        push_phase(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, '0, hold, 1'b0);
        push_phase(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, '0, hold, 1'b0);
        push_phase(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, '0, hold, 1'b1);
      end
    endcase
  endtask

  // requests are predicted before results of the same edge are checked
  always @(posedge clk) begin
    pin_phase_t want;
    if (!rst_n) begin
      pins_word    = '0;
      hold_setting = plbm_pkg::HOLD_RESET;
      phases_due.delete();
    end else begin
      if (cfg_we) hold_setting = cfg_data;
      if (in_ch.valid && in_ch.ready)
        predict_pin_phases(in_ch.func, in_ch.value, in_ch.bus_in);
      if (out_ch.valid && out_ch.ready) begin
        if (phases_due.size() == 0) begin
          report_mismatch("pin phase item with nothing expected");
        end else begin
          want = phases_due.pop_front();
          if (out_ch.cs_n !== want.cs_n)
            report_mismatch($sformatf("cs_n %b, expected %b", out_ch.cs_n, want.cs_n));
          if (out_ch.dc !== want.dc)
            report_mismatch($sformatf("dc %b, expected %b", out_ch.dc, want.dc));
          if (out_ch.wr_n !== want.wr_n)
            report_mismatch($sformatf("wr_n %b, expected %b", out_ch.wr_n, want.wr_n));
          if (out_ch.rd_n !== want.rd_n)
            report_mismatch($sformatf("rd_n %b, expected %b", out_ch.rd_n, want.rd_n));
          if (out_ch.reset_n !== want.reset_n)
            report_mismatch($sformatf("reset_n %b, expected %b", out_ch.reset_n,
                                      want.reset_n));
          if (out_ch.data_out !== want.data_out)
            report_mismatch($sformatf("data_out %h, expected %h", out_ch.data_out,
                                      want.data_out));
          if (out_ch.data_drive !== want.data_drive)
            report_mismatch($sformatf("data_drive %b, expected %b", out_ch.data_drive,
                                      want.data_drive));
          if (out_ch.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, expected %h", out_ch.read_data,
                                      want.read_data));
          if (out_ch.hold_ms !== want.hold_ms)
            report_mismatch($sformatf("hold_ms %0d, expected %0d", out_ch.hold_ms,
                                      want.hold_ms));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", out_ch.last, want.last));
        end
        phases_seen++;
      end
    end
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // returns at the edge that takes the item, valid still high
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] value,
                              input logic [DATA_W-1:0] bus_in);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid  <= 1'b0;
      in_ch.func   <= FUNC_W'($urandom);
      in_ch.value  <= DATA_W'($urandom);
      in_ch.bus_in <= DATA_W'($urandom);
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= func;
    in_ch.value  <= value;
    in_ch.bus_in <= bus_in;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_all_phases;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (phases_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hold(input logic [HOLD_W-1:0] hold);
    wait_all_phases();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= hold;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= HOLD_W'($urandom);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [HOLD_W-1:0] pick_hold();
    case ($urandom_range(5))
      0:       return '0;
      1:       return plbm_pkg::HOLD_MIN;
      2:       return plbm_pkg::HOLD_MAX;
      3:       return plbm_pkg::HOLD_MAX + 1'b1;
      4:       return '1;
      default: return HOLD_W'($urandom_range(1023));
    endcase
  endfunction

  task automatic send_random_request;
    logic [FUNC_W-1:0] func;
    func = FUNC_W'($urandom_range(plbm_pkg::FUNC_PANEL_RST, plbm_pkg::FUNC_CMD_WR));
    send_request(func, pick_word(), pick_word());
  endtask

  task automatic test_bus_cycles;
    send_request(plbm_pkg::FUNC_DATA_RD, 16'h1234, 16'hffff);  // latch still zero from reset
    send_request(plbm_pkg::FUNC_CMD_WR, 16'hffff, 16'h0000);   // upper byte cleared
    send_request(plbm_pkg::FUNC_DATA_RD, 16'hffff, 16'h0000);
    send_request(plbm_pkg::FUNC_DATA_WR, 16'hffff, 16'hffff);
    send_request(plbm_pkg::FUNC_PANEL_RST, 16'h0000, 16'hffff);
    send_request(plbm_pkg::FUNC_CMD_WR, 16'hab00, 16'h5a5a);
    send_request(plbm_pkg::FUNC_DATA_WR, 16'h0000, 16'h0000);
    send_request(plbm_pkg::FUNC_DATA_WR, 16'ha5a5, 16'h0000);
    send_request(plbm_pkg::FUNC_DATA_RD, 16'h0000, 16'h5a5a);
    send_request(plbm_pkg::FUNC_DATA_RD, 16'h0000, 16'ha5a5);
    send_request(plbm_pkg::FUNC_CMD_WR, 16'h00ff, 16'hffff);
    send_request(plbm_pkg::FUNC_CMD_WR, 16'h0000, 16'h0000);
  endtask

  task automatic test_reset_hold_range;
    logic [HOLD_W-1:0] holds[8];
    holds = '{10'd0, plbm_pkg::HOLD_MIN, 10'd2, 10'd999, plbm_pkg::HOLD_MAX,
              plbm_pkg::HOLD_MAX + 10'd1, 10'h3ff, plbm_pkg::HOLD_RESET};
    foreach (holds[i]) begin
      write_hold(holds[i]);
      send_request(plbm_pkg::FUNC_PANEL_RST, pick_word(), pick_word());
    end
  endtask

  task automatic test_random_traffic(input int n);
    write_hold(pick_hold());
    repeat (n) send_random_request();
  endtask

  task automatic test_drained_requests(input int n);
    repeat (n) begin
      wait_all_phases();
      send_random_request();
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = plbm_pkg::FUNC_CMD_WR;
    in_ch.value  = '0;
    in_ch.bus_in = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_bus_cycles();
    test_reset_hold_range();

    send_idle_pct = 22;
    recv_idle_pct = 56;
    test_random_traffic(140);
    test_drained_requests(10);
    send_idle_pct = 56;
    recv_idle_pct = 22;
    test_random_traffic(140);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(140);

    wait_all_phases();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** parallel_lcd_bus_master: PASSED **");
    end else begin
      $display("** parallel_lcd_bus_master: FAILED **");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d pin phases still expected", phases_due.size());
    $display("** parallel_lcd_bus_master: FAILED **");
    $finish;
  end

endmodule

/* parallel_lcd_bus_master.f */
hw/rtl/plbm_pkg.sv
hw/rtl/plbm_in_if.sv
hw/rtl/plbm_out_if.sv
hw/rtl/plbm_front.sv
hw/rtl/plbm_queue.sv
hw/rtl/plbm_back.sv
hw/rtl/parallel_lcd_bus_master.sv
bench/tb.sv
